[rtl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and character tables of the Intel HEX encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int RECORD_BYTES_DEF = 16;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;
    localparam int REG_IDX_W        = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_START_ADDRESS = 1'b0;
    localparam logic [15:0]          START_ADDRESS_RST = 16'h0100;
    localparam logic [7:0]           REC_TYPE_DATA     = 8'h00;
    localparam logic [3:0]           EOF_LAST_IDX      = 4'd11;
    localparam logic [6:0]           CHR_COLON         = 7'h3A;
    localparam logic [6:0]           CHR_NEWLINE       = 7'h0A;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COLON,
        ST_LEN,
        ST_ADDR_HI,
        ST_ADDR_LO,
        ST_TYPE,
        ST_DATA,
        ST_CSUM,
        ST_NL,
        ST_EOF
    } t_state;

    typedef enum logic [2:0] {
        CH_COLON,
        CH_BYTE_HI,
        CH_BYTE_LO,
        CH_NL,
        CH_EOF
    } t_chr;

    typedef enum logic [2:0] {
        BS_LEN,
        BS_ADDR_HI,
        BS_ADDR_LO,
        BS_TYPE,
        BS_DATA,
        BS_CSUM
    } t_bsel;

    typedef struct packed {
        logic  emit;
        t_chr  chr_sel;
        t_bsel byte_sel;
        logic  last;
        logic  rec_done;
        logic  eof_done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_last;
        logic fill_empty;
        logic data_last;
        logic eof_last;
    } t_stat;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'b000, nib};
        end else begin
            c = 7'h37 + {3'b000, nib};
        end
        return c;
    endfunction

    // ":00000001FF\n"
    function automatic logic [6:0] eof_char(input logic [3:0] idx);
        logic [6:0] c;
        case (idx)
            4'd0:    c = CHR_COLON;
            4'd8:    c = 7'h31;
            4'd9,
            4'd10:   c = 7'h46;
            4'd11:   c = CHR_NEWLINE;
            default: c = 7'h30;
        endcase
        return c;
    endfunction

endpackage

[rtl/intel_hex_record_encoder.sv]
// A byte that fills a record, or an end item, moves the sequencer out of idle, and its
// first character passes the state register, then the output character register; a data
// byte that leaves the record open is only stored. Input is held off while text goes out.
// Throughput: one character per cycle from the single output character register unless
// the output stalls; a record of N bytes is 12 + 2N characters, the end record 12.
// Reset: synchronous, active low; fill count cleared, start and load address 0x0100.
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// Byte stream in, Intel HEX text out one ASCII character per transfer.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder
    import ihex_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tuser,   // [0] kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [6:0] character, [7] zero
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cmd        cmd;
    t_stat       stat;
    logic        accept;
    logic        cfg_we;
    logic        reg_hit;
    logic [15:0] start;
    logic [6:0]  out_char;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_START_ADDRESS);
    assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(DATA_W - 16){1'b0}}, start} : '0;

    ihex_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_kind  (s_axis_tuser),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    ihex_dp #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (pwdata[15:0]),
        .i_cmd      (cmd),
        .i_out_ready(m_axis_tready),
        .o_stat     (stat),
        .o_start    (start),
        .o_out_valid(m_axis_tvalid),
        .o_out_char (out_char),
        .o_out_last (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

[rtl/ihex_ctrl.sv]
// ----------------------------------------------------------------------------
// ihex_ctrl
// Record sequencer: walks the fields of a data record and the end record.
// ----------------------------------------------------------------------------
module ihex_ctrl
    import ihex_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_kind,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_nib, n_nib;
    logic   r_eof_pend, n_eof_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_nib      <= 1'b0;
            r_eof_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_nib      <= n_nib;
            r_eof_pend <= n_eof_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_nib      = r_nib;
        n_eof_pend = r_eof_pend;
        o_ready    = 1'b0;
        o_cmd      = '{emit: 1'b0, chr_sel: CH_COLON, byte_sel: BS_LEN,
                       last: 1'b0, rec_done: 1'b0, eof_done: 1'b0};
        o_cmd.chr_sel = r_nib ? CH_BYTE_LO : CH_BYTE_HI;

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                n_nib   = 1'b0;
                if (i_accept) begin
                    n_eof_pend = i_kind;
                    if (!i_kind) begin
                        if (i_stat.fill_last) begin
                            n_state = ST_COLON;
                        end
                    end else if (i_stat.fill_empty) begin
                        n_state = ST_EOF;
                    end else begin
                        n_state = ST_COLON;
                    end
                end
            end
            ST_COLON: begin
                o_cmd.chr_sel = CH_COLON;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_LEN;
                end
            end
            ST_LEN, ST_ADDR_HI, ST_ADDR_LO, ST_TYPE, ST_DATA, ST_CSUM: begin
                case (r_state)
                    ST_LEN:     o_cmd.byte_sel = BS_LEN;
                    ST_ADDR_HI: o_cmd.byte_sel = BS_ADDR_HI;
                    ST_ADDR_LO: o_cmd.byte_sel = BS_ADDR_LO;
                    ST_TYPE:    o_cmd.byte_sel = BS_TYPE;
                    ST_DATA:    o_cmd.byte_sel = BS_DATA;
                    default:    o_cmd.byte_sel = BS_CSUM;
                endcase
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_nib      = !r_nib;
                    if (r_nib) begin
                        case (r_state)
                            ST_LEN:     n_state = ST_ADDR_HI;
                            ST_ADDR_HI: n_state = ST_ADDR_LO;
                            ST_ADDR_LO: n_state = ST_TYPE;
                            ST_TYPE:    n_state = ST_DATA;
                            ST_DATA:    n_state = i_stat.data_last ? ST_CSUM : ST_DATA;
                            default:    n_state = ST_NL;
                        endcase
                    end
                end
            end
            ST_NL: begin
                o_cmd.chr_sel = CH_NL;
                o_cmd.last    = !r_eof_pend;
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.rec_done = 1'b1;
                    n_state        = r_eof_pend ? ST_EOF : ST_IDLE;
                end
            end
            ST_EOF: begin
                o_cmd.chr_sel = CH_EOF;
                o_cmd.last    = i_stat.eof_last;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.eof_last) begin
                        o_cmd.eof_done = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/ihex_dp.sv]
// ----------------------------------------------------------------------------
// ihex_dp
// Record buffer, address and checksum registers, character output stage.
// ----------------------------------------------------------------------------
module ihex_dp
    import ihex_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_kind,
    input  logic [7:0]  i_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic [15:0] o_start,
    output logic        o_out_valid,
    output logic [6:0]  o_out_char,
    output logic        o_out_last
);

    localparam int FILL_W = $clog2(RECORD_BYTES + 1);
    localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int DEPTH  = 2 ** IDX_W;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rdata;
    logic [7:0]        r_cur;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic [15:0]       r_start;
    logic [15:0]       r_addr;
    logic [7:0]        r_sum;
    logic [3:0]        r_eof;
    logic              r_oval;
    logic [6:0]        r_ochar;
    logic              r_olast;

    logic [7:0] len_byte;
    logic [7:0] byte_val;
    logic [6:0] n_char;
    logic       hi_emit;

    assign len_byte = {{(8 - FILL_W){1'b0}}, r_fill};
    assign hi_emit  = i_cmd.emit && (i_cmd.chr_sel == CH_BYTE_HI);

    always_comb begin
        case (i_cmd.byte_sel)
            BS_LEN:     byte_val = len_byte;
            BS_ADDR_HI: byte_val = r_addr[15:8];
            BS_ADDR_LO: byte_val = r_addr[7:0];
            BS_TYPE:    byte_val = REC_TYPE_DATA;
            BS_DATA:    byte_val = (i_cmd.chr_sel == CH_BYTE_HI) ? r_rdata : r_cur;
            BS_CSUM:    byte_val = ~r_sum + 8'd1;
            default:    byte_val = REC_TYPE_DATA;
        endcase
    end

    always_comb begin
        case (i_cmd.chr_sel)
            CH_COLON:   n_char = CHR_COLON;
            CH_BYTE_HI: n_char = hex_char(byte_val[7:4]);
            CH_BYTE_LO: n_char = hex_char(byte_val[3:0]);
            CH_NL:      n_char = CHR_NEWLINE;
            CH_EOF:     n_char = eof_char(r_eof);
            default:    n_char = CHR_NEWLINE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_kind) begin
            r_mem[r_fill[IDX_W-1:0]] <= i_data;
        end
        r_rdata <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_idx <= '0;
            r_sum <= '0;
        end else if (hi_emit && (i_cmd.byte_sel != BS_CSUM)) begin
            r_sum <= r_sum + byte_val;
            if (i_cmd.byte_sel == BS_DATA) begin
                r_cur <= r_rdata;
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_ochar <= n_char;
            r_olast <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_start <= START_ADDRESS_RST;
            r_addr  <= START_ADDRESS_RST;
            r_eof   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_data;
                r_addr  <= i_cfg_data;
            end else if (i_cmd.eof_done) begin
                r_addr <= r_start;
            end else if (i_cmd.rec_done) begin
                r_addr <= r_addr + 16'(r_fill);
            end

            if (i_cmd.rec_done || i_cmd.eof_done) begin
                r_fill <= '0;
            end else if (i_accept && !i_kind) begin
                r_fill <= r_fill + 1'b1;
            end

            if (i_cmd.eof_done) begin
                r_eof <= '0;
            end else if (i_cmd.emit && (i_cmd.chr_sel == CH_EOF)) begin
                r_eof <= r_eof + 4'd1;
            end

            if (i_cmd.emit) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_stat.out_free   = !r_oval || i_out_ready;
    assign o_stat.fill_last  = (r_fill == FILL_W'(RECORD_BYTES - 1));
    assign o_stat.fill_empty = (r_fill == '0);
    assign o_stat.data_last  = (r_idx == r_fill);
    assign o_stat.eof_last   = (r_eof == EOF_LAST_IDX);

    assign o_start     = r_start;
    assign o_out_valid = r_oval;
    assign o_out_char  = r_ochar;
    assign o_out_last  = r_olast;

endmodule

[rtl/ihex_checker.sv]
// ----------------------------------------------------------------------------
// ihex_checker
// Port-level checks of the Intel HEX encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ihex_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // end item always produces text, so input closes
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input ready right after end item");

    // no new input while a character run is still going out
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready before run finished");

    // characters are 7-bit ASCII
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("non-ASCII character");

endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (.*);
